// ===== hw/rtl/rbas_pkg.sv =====
package rbas_pkg;

    localparam int NUM_REGS_DEF      = 256;
    localparam int STACK_DEPTH_DEF   = 256;
    localparam int CONTEXT_DEPTH_DEF = 16;

    typedef enum logic [3:0] {
        OP_INIT        = 4'd0,
        OP_ALLOC       = 4'd1,
        OP_PUSH_REG    = 4'd2,
        OP_POP         = 4'd3,
        OP_PUSH_CTX    = 4'd4,
        OP_POP_CTX     = 4'd5,
        OP_PROTECT_OUT = 4'd6,
        OP_PROTECT_IN  = 4'd7,
        OP_CLEAR       = 4'd8,
        OP_SET         = 4'd9,
        OP_KEEP        = 4'd10,
        OP_UNKEEP      = 4'd11,
        OP_CLEAR_TEMPS = 4'd12,
        OP_ALLOC_KEPT  = 4'd13,
        OP_FIRST_FREE  = 4'd14,
        OP_PEEK        = 4'd15
    } alloc_op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_REG_STK = 2'd2,
        ST_CTX_STK = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_READ,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic init_step;
        logic scan_start;
        logic scan_step;
        logic mem_read;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic needs_scan;
        logic needs_read;
        logic is_init;
    } sts_t;

endpackage

// ===== hw/rtl/rbas_if.sv =====
interface rbas_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] opcode;
    logic [7:0] reg_in;
    logic       protect;
    modport source (output valid, opcode, reg_in, protect, input ready);
    modport sink (input valid, opcode, reg_in, protect, output ready);
endinterface

interface rbas_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_out;
    logic [1:0] status;
    logic       answer;
    logic [8:0] stack_count;
    logic [8:0] temps_used;
    logic [7:0] highest_temp;
    logic       error_flag;
    modport source (output valid, reg_out, status, answer, stack_count, temps_used,
                    highest_temp, error_flag, input ready);
    modport sink (input valid, reg_out, status, answer, stack_count, temps_used,
                  highest_temp, error_flag, output ready);
endinterface

// ===== hw/rtl/register_bitmap_allocator_stack_core.sv =====
// channel   dir  signals
// in_ch     in   valid ready opcode reg_in protect
// out_ch    out  valid ready reg_out status answer stack_count temps_used
//                highest_temp error_flag
// cfg       in   cfg_we cfg_wdata (num_locals)
// Alloc, alloc kept and first free search the bitmap for a free register in
// 32-register segments before execute.
// After reset the input is held off while the reset bitmap loads;
// init reloads it in its own execute cycle.
// Pop and peek on a non-empty stack read the stack memory in a read state before execute.
// A result holds until taken; no new item is accepted meanwhile.
module register_bitmap_allocator_stack_core
    import rbas_pkg::*;
#(
    parameter int NUM_REGS      = NUM_REGS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int CONTEXT_DEPTH = CONTEXT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    rbas_in_if.sink    in_ch,
    rbas_out_if.source out_ch
);
    cmd_t cmd;
    sts_t sts;

    rbas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rbas_dp #(
        .NUM_REGS     (NUM_REGS),
        .STACK_DEPTH  (STACK_DEPTH),
        .CONTEXT_DEPTH(CONTEXT_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .opcode      (in_ch.opcode),
        .reg_in      (in_ch.reg_in),
        .protect     (in_ch.protect),
        .cmd         (cmd),
        .sts         (sts),
        .reg_out     (out_ch.reg_out),
        .status      (out_ch.status),
        .answer      (out_ch.answer),
        .stack_count (out_ch.stack_count),
        .temps_used  (out_ch.temps_used),
        .highest_temp(out_ch.highest_temp),
        .error_flag  (out_ch.error_flag)
    );
endmodule

// ===== hw/rtl/rbas_ram.sv =====
module rbas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== hw/rtl/rbas_ctrl.sv =====
module rbas_ctrl
    import rbas_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    output logic   out_valid,
    input  logic   out_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.needs_scan && !sts.scan_done)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (sts.needs_read)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.is_init)
                begin
                    cmd.init_step = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before taken");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_SCAN)
        else $error("load did not start scan");
endmodule

// ===== hw/rtl/rbas_dp.sv =====
module rbas_dp
    import rbas_pkg::*;
#(
    parameter int NUM_REGS      = NUM_REGS_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int CONTEXT_DEPTH = CONTEXT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    input  logic [3:0] opcode,
    input  logic [7:0] reg_in,
    input  logic       protect,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic [7:0] reg_out,
    output logic [1:0] status,
    output logic       answer,
    output logic [8:0] stack_count,
    output logic [8:0] temps_used,
    output logic [7:0] highest_temp,
    output logic       error_flag
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(CONTEXT_DEPTH);
    localparam int CCW = $clog2(CONTEXT_DEPTH + 1);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int RW = $clog2(NUM_REGS);
    localparam int SEG = 32;
    localparam int NSEG = (NUM_REGS + SEG - 1) / SEG;
    localparam int NSW = $clog2(NSEG + 1);

    logic [8:0]          num_locals_reg;
    logic [NUM_REGS-1:0] busy_reg, busy_next;
    logic [NUM_REGS-1:0] keep_reg, keep_next;
    logic [NUM_REGS-1:0] ctx_reg [CONTEXT_DEPTH];
    logic [SCW-1:0]      sp_reg, sp_next;
    logic [CCW-1:0]      cc_reg, cc_next;
    logic [7:0]          max_reg, max_next;
    logic [8:0]          tc_reg, tc_next;
    logic                err_reg, err_next;
    logic [3:0]          op_reg;
    logic [7:0]          rin_reg;
    logic                prot_reg;
    logic [NSW-1:0]      seg_reg;
    logic                found_reg;
    logic [7:0]          free_reg;
    logic [7:0]          rout_next;
    logic [1:0]          st_next;
    logic                ans_next;
    logic [7:0]          rout_reg;
    logic [1:0]          st_reg;
    logic                ans_reg;
    logic                init_pend_reg;
    logic [7:0]          rdata;
    logic                ram_we;
    logic [SW-1:0]       ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata;
    logic [NUM_REGS-1:0] ctx_top;
    logic                ctx_wr;
    logic [CW-1:0]       ctx_waddr;
    logic [NUM_REGS-1:0] ctx_wdata;
    logic [SEG-1:0]      seg_free;
    logic                seg_hit;
    logic [4:0]          seg_pos;
    logic [NUM_REGS-1:0] reserved;
    logic [NUM_REGS-1:0] temp_range;

    function automatic logic [NUM_REGS-1:0] reserved_mask(input logic [8:0] nl);
        logic [NUM_REGS-1:0] m;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            m[i] = (i == 0) || (i < int'(nl));
        end
        return m;
    endfunction

    assign reserved = reserved_mask(num_locals_reg);

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            temp_range[i] = (i >= int'(num_locals_reg)) && (i <= int'(max_reg));
        end
    end

    always_comb
    begin
        seg_free = '0;
        for (int b = 0; b < SEG; b++)
        begin
            if (int'(seg_reg) * SEG + b < NUM_REGS)
            begin
                seg_free[b] = !busy_reg[int'(seg_reg) * SEG + b]
                              && !reserved[int'(seg_reg) * SEG + b];
            end
        end
        seg_hit = |seg_free;
        seg_pos = '0;
        for (int b = SEG - 1; b >= 0; b--)
        begin
            if (seg_free[b])
            begin
                seg_pos = 5'(b);
            end
        end
    end

    assign sts.scan_done  = found_reg || (int'(seg_reg) >= NSEG);
    assign sts.needs_scan = (op_reg == OP_ALLOC) || (op_reg == OP_ALLOC_KEPT)
                            || (op_reg == OP_FIRST_FREE);
    assign sts.needs_read = ((op_reg == OP_POP) || (op_reg == OP_PEEK)) && (sp_reg != '0);
    assign sts.init_done  = !init_pend_reg;
    assign sts.is_init    = (op_reg == OP_INIT);

    assign ctx_top = (cc_reg != '0) ? ctx_reg[CW'(cc_reg - 1'b1)] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_locals_reg <= '0;
            init_pend_reg  <= 1'b1;
            seg_reg        <= '0;
            found_reg      <= 1'b0;
            free_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_locals_reg <= cfg_wdata;
            end
            if (cmd.init_step)
            begin
                init_pend_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                seg_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (seg_hit)
                begin
                    found_reg <= 1'b1;
                    free_reg  <= 8'(int'(seg_reg) * SEG + int'(seg_pos));
                end
                else
                begin
                    seg_reg <= seg_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            rin_reg  <= reg_in;
            prot_reg <= protect;
        end
        if (cmd.exec)
        begin
            rout_reg <= rout_next;
            st_reg   <= st_next;
            ans_reg  <= ans_next;
        end
        if (ctx_wr && cmd.exec)
        begin
            ctx_reg[ctx_waddr] <= ctx_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            keep_reg <= '0;
            sp_reg   <= '0;
            cc_reg   <= '0;
            max_reg  <= '0;
            tc_reg   <= '0;
            err_reg  <= 1'b0;
        end
        else if (cmd.init_step)
        begin
            busy_reg <= reserved;
            keep_reg <= '0;
            sp_reg   <= '0;
            cc_reg   <= '0;
            max_reg  <= '0;
            tc_reg   <= '0;
            err_reg  <= 1'b0;
        end
        else if (cmd.exec)
        begin
            busy_reg <= busy_next;
            keep_reg <= keep_next;
            sp_reg   <= sp_next;
            cc_reg   <= cc_next;
            max_reg  <= max_next;
            tc_reg   <= tc_next;
            err_reg  <= err_next;
        end
    end

    assign ram_raddr = SW'(sp_reg - 1'b1);

    rbas_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we && cmd.exec),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.mem_read),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        logic in_rng;
        logic rsv_in;
        logic full;
        logic [8:0] tc_inc;
        in_rng    = int'(rin_reg) < NUM_REGS;
        rsv_in    = in_rng ? reserved[RW'(rin_reg)] : 1'b0;
        full      = int'(sp_reg) >= STACK_DEPTH;
        tc_inc    = (tc_reg < 9'd511) ? tc_reg + 9'd1 : tc_reg;
        busy_next = busy_reg;
        keep_next = keep_reg;
        sp_next   = sp_reg;
        cc_next   = cc_reg;
        max_next  = max_reg;
        tc_next   = tc_reg;
        err_next  = err_reg;
        rout_next = '0;
        st_next   = ST_OK;
        ans_next  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = SW'(sp_reg);
        ram_wdata = '0;
        ctx_wr    = 1'b0;
        ctx_waddr = CW'(cc_reg - 1'b1);
        ctx_wdata = ctx_top;
        case (op_reg)
            OP_INIT:
            begin
            end
            OP_ALLOC, OP_ALLOC_KEPT:
            begin
                if (full)
                begin
                    st_next = ST_REG_STK;
                end
                else if (!found_reg)
                begin
                    err_next = 1'b1;
                    st_next  = ST_NO_FREE;
                end
                else
                begin
                    busy_next[RW'(free_reg)] = 1'b1;
                    ram_we    = 1'b1;
                    ram_wdata = free_reg;
                    sp_next   = sp_reg + 1'b1;
                    if (free_reg > max_reg)
                    begin
                        max_next = free_reg;
                        tc_next  = tc_inc;
                    end
                    if (op_reg == OP_ALLOC_KEPT)
                    begin
                        keep_next[RW'(free_reg)] = 1'b1;
                    end
                    rout_next = free_reg;
                end
            end
            OP_PUSH_REG:
            begin
                if (full)
                begin
                    st_next = ST_REG_STK;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = rin_reg;
                    sp_next   = sp_reg + 1'b1;
                    if ({1'b0, rin_reg} >= num_locals_reg)
                    begin
                        tc_next = tc_inc;
                    end
                    rout_next = rin_reg;
                end
            end
            OP_POP:
            begin
                if (sp_reg == '0)
                begin
                    st_next = ST_REG_STK;
                end
                else
                begin
                    sp_next   = sp_reg - 1'b1;
                    rout_next = rdata;
                    if (int'(rdata) < NUM_REGS)
                    begin
                        if (prot_reg)
                        begin
                            busy_next[RW'(rdata)] = 1'b1;
                        end
                        else if (!reserved[RW'(rdata)])
                        begin
                            busy_next[RW'(rdata)] = 1'b0;
                        end
                    end
                    if (prot_reg && ({1'b0, rdata} >= num_locals_reg))
                    begin
                        if (cc_reg == '0)
                        begin
                            st_next = ST_CTX_STK;
                        end
                        else if (int'(rdata) < NUM_REGS)
                        begin
                            ctx_wr = 1'b1;
                            ctx_wdata[RW'(rdata)] = 1'b1;
                        end
                    end
                end
            end
            OP_PUSH_CTX:
            begin
                if (int'(cc_reg) >= CONTEXT_DEPTH)
                begin
                    st_next = ST_CTX_STK;
                end
                else
                begin
                    ctx_wr    = 1'b1;
                    ctx_waddr = CW'(cc_reg);
                    ctx_wdata = '0;
                    cc_next   = cc_reg + 1'b1;
                end
            end
            OP_POP_CTX:
            begin
                if (cc_reg == '0)
                begin
                    st_next = ST_CTX_STK;
                end
                else
                begin
                    cc_next   = cc_reg - 1'b1;
                    busy_next = busy_reg & ~(ctx_top & ~reserved);
                end
            end
            OP_PROTECT_OUT:
            begin
                if ({1'b0, rin_reg} < num_locals_reg)
                begin
                    ans_next = 1'b1;
                end
                else if (!in_rng || rsv_in || busy_reg[RW'(rin_reg)])
                begin
                    ans_next = 1'b1;
                    if (cc_reg == '0)
                    begin
                        st_next = ST_CTX_STK;
                    end
                    else if (in_rng)
                    begin
                        ctx_wr = 1'b1;
                        ctx_wdata[RW'(rin_reg)] = 1'b0;
                    end
                end
            end
            OP_PROTECT_IN:
            begin
                if (cc_reg == '0)
                begin
                    st_next = ST_CTX_STK;
                end
                else if (in_rng)
                begin
                    ctx_wr = 1'b1;
                    ctx_wdata[RW'(rin_reg)] = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                if (in_rng && !rsv_in)
                begin
                    busy_next[RW'(rin_reg)] = 1'b0;
                end
            end
            OP_SET:
            begin
                if (in_rng && ({1'b0, rin_reg} >= num_locals_reg))
                begin
                    busy_next[RW'(rin_reg)] = 1'b1;
                end
            end
            OP_KEEP:
            begin
                if (in_rng)
                begin
                    keep_next[RW'(rin_reg)] = 1'b1;
                end
            end
            OP_UNKEEP:
            begin
                if (in_rng)
                begin
                    keep_next[RW'(rin_reg)] = 1'b0;
                end
            end
            OP_CLEAR_TEMPS:
            begin
                busy_next = busy_reg & ~(temp_range & ~keep_reg & ~reserved);
            end
            OP_FIRST_FREE:
            begin
                if (found_reg)
                begin
                    rout_next = free_reg;
                end
                else
                begin
                    err_next = 1'b1;
                    st_next  = ST_NO_FREE;
                end
            end
            default:
            begin
                if (sp_reg == '0)
                begin
                    st_next = ST_REG_STK;
                end
                else
                begin
                    rout_next = rdata;
                end
            end
        endcase
    end

    assign reg_out      = rout_reg;
    assign status       = st_reg;
    assign answer       = ans_reg;
    assign stack_count  = 9'(sp_reg);
    assign temps_used   = tc_reg;
    assign highest_temp = max_reg;
    assign error_flag   = err_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(sp_reg) <= STACK_DEPTH)
        else $error("stack pointer out of range");
    a_cc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cc_reg) <= CONTEXT_DEPTH)
        else $error("context count out of range");
    a_reg0_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && found_reg && sts.needs_scan) |-> !reserved[RW'(free_reg)])
        else $error("free search returned reserved register");
endmodule

// ===== sim/register_bitmap_allocator_stack_core_tb.sv =====
`timescale 1ns / 100ps

module register_bitmap_allocator_stack_core_tb
    import rbas_pkg::*;
;

    localparam int NREGS     = NUM_REGS_DEF;
    localparam int STK_DEPTH = STACK_DEPTH_DEF;
    localparam int CTX_DEPTH = CONTEXT_DEPTH_DEF;

    typedef struct packed {
        logic [7:0] reg_out;
        logic [1:0] status;
        logic       answer;
        logic [8:0] stack_count;
        logic [8:0] temps_used;
        logic [7:0] highest_temp;
        logic       error_flag;
    } alloc_result_t;

    class alloc_scoreboard;
        int unsigned          locals;
        logic [NREGS-1:0]     busy;
        logic [NREGS-1:0]     kept;
        logic [7:0]           stk [STK_DEPTH];
        int unsigned          stk_cnt;
        logic [NREGS-1:0]     ctx [CTX_DEPTH];
        int unsigned          ctx_cnt;
        int unsigned          hi_temp;
        int unsigned          temp_cnt;
        logic                 err;
        alloc_result_t        pending [$];
        int unsigned          mismatches;
        int unsigned          results_seen;

        function new();
            locals = 0;
            mismatches = 0;
            results_seen = 0;
            clear_state();
        endfunction

        function bit reserved(int unsigned r);
            return r == 0 || r < locals;
        endfunction

        function bit is_busy(int unsigned r);
            if (r >= NREGS || reserved(r))
                return 1'b1;
            return busy[r];
        endfunction

        function void free_one(int unsigned r);
            if (r < NREGS && !reserved(r))
                busy[r] = 1'b0;
        endfunction

        function void bump();
            if (temp_cnt < 511)
                temp_cnt++;
        endfunction

        function int first_free();
            for (int i = 0; i < NREGS; i++)
            begin
                if (!is_busy(i))
                    return i;
            end
            return -1;
        endfunction

        function void clear_state();
            busy = '0;
            kept = '0;
            for (int i = 0; i < CTX_DEPTH; i++)
                ctx[i] = '0;
            for (int i = 0; i < NREGS; i++)
            begin
                if (reserved(i))
                    busy[i] = 1'b1;
            end
            stk_cnt = 0;
            ctx_cnt = 0;
            hi_temp = 0;
            temp_cnt = 0;
            err = 1'b0;
        endfunction

        function void note_item(alloc_op_t op, logic [7:0] r, logic prot);
            alloc_result_t res;
            int            v;
            res = '0;
            res.status = ST_OK;
            case (op)
                OP_INIT: clear_state();
                OP_ALLOC, OP_ALLOC_KEPT:
                begin
                    if (stk_cnt >= STK_DEPTH)
                        res.status = ST_REG_STK;
                    else
                    begin
                        v = first_free();
                        if (v < 0)
                        begin
                            err = 1'b1;
                            res.status = ST_NO_FREE;
                        end
                        else
                        begin
                            busy[v] = 1'b1;
                            stk[stk_cnt++] = v[7:0];
                            if (v > hi_temp)
                            begin
                                hi_temp = v;
                                bump();
                            end
                            if (op == OP_ALLOC_KEPT)
                                kept[v] = 1'b1;
                            res.reg_out = v[7:0];
                        end
                    end
                end
                OP_PUSH_REG:
                begin
                    if (stk_cnt >= STK_DEPTH)
                        res.status = ST_REG_STK;
                    else
                    begin
                        stk[stk_cnt++] = r;
                        if (r >= locals)
                            bump();
                        res.reg_out = r;
                    end
                end
                OP_POP:
                begin
                    if (stk_cnt == 0)
                        res.status = ST_REG_STK;
                    else
                    begin
                        v = int'(stk[--stk_cnt]);
                        res.reg_out = v[7:0];
                        if (prot)
                            busy[v] = 1'b1;
                        else if (v >= locals)
                            free_one(v);
                        if (prot && v >= locals)
                        begin
                            if (ctx_cnt == 0)
                                res.status = ST_CTX_STK;
                            else
                                ctx[ctx_cnt-1][v] = 1'b1;
                        end
                    end
                end
                OP_PUSH_CTX:
                begin
                    if (ctx_cnt >= CTX_DEPTH)
                        res.status = ST_CTX_STK;
                    else
                    begin
                        ctx[ctx_cnt] = '0;
                        ctx_cnt++;
                    end
                end
                OP_POP_CTX:
                begin
                    if (ctx_cnt == 0)
                        res.status = ST_CTX_STK;
                    else
                    begin
                        ctx_cnt--;
                        for (int i = 0; i < NREGS; i++)
                        begin
                            if (ctx[ctx_cnt][i])
                                free_one(i);
                        end
                    end
                end
                OP_PROTECT_OUT:
                begin
                    if (r < locals)
                        res.answer = 1'b1;
                    else if (is_busy(r))
                    begin
                        res.answer = 1'b1;
                        if (ctx_cnt == 0)
                            res.status = ST_CTX_STK;
                        else
                            ctx[ctx_cnt-1][r] = 1'b0;
                    end
                end
                OP_PROTECT_IN:
                begin
                    if (ctx_cnt == 0)
                        res.status = ST_CTX_STK;
                    else
                        ctx[ctx_cnt-1][r] = 1'b1;
                end
                OP_CLEAR:
                begin
                    if (r >= locals)
                        free_one(r);
                end
                OP_SET:
                begin
                    if (r >= locals)
                        busy[r] = 1'b1;
                end
                OP_KEEP: kept[r] = 1'b1;
                OP_UNKEEP: kept[r] = 1'b0;
                OP_CLEAR_TEMPS:
                begin
                    for (int i = locals; i <= hi_temp && i < NREGS; i++)
                    begin
                        if (!kept[i])
                            free_one(i);
                    end
                end
                OP_FIRST_FREE:
                begin
                    v = first_free();
                    if (v < 0)
                    begin
                        err = 1'b1;
                        res.status = ST_NO_FREE;
                    end
                    else
                        res.reg_out = v[7:0];
                end
                default:
                begin
                    if (stk_cnt == 0)
                        res.status = ST_REG_STK;
                    else
                        res.reg_out = stk[stk_cnt-1];
                end
            endcase
            res.stack_count = stk_cnt[8:0];
            res.temps_used = temp_cnt[8:0];
            res.highest_temp = hi_temp[7:0];
            res.error_flag = err;
            pending.push_back(res);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp: reg %0d st %0d ans %0d stk %0d tmp %0d hi %0d err %0d",
                             exp.reg_out, exp.status, exp.answer, exp.stack_count,
                             exp.temps_used, exp.highest_temp, exp.error_flag);
                    $display("         got: reg %0d st %0d ans %0d stk %0d tmp %0d hi %0d err %0d",
                             got.reg_out, got.status, got.answer, got.stack_count,
                             got.temps_used, got.highest_temp, got.error_flag);
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    rbas_in_if  in_ch ();
    rbas_out_if out_ch ();

    register_bitmap_allocator_stack_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    alloc_scoreboard sb;
    int unsigned     items_sent;
    bit              hold_off;
    bit              stall_enable;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout waiting for results");
        $display("** register_bitmap_allocator_stack_core: FAILED **");
        $finish;
    end

    // receiver: own stall pattern plus a long hold-off on request
    initial
    begin
        int unsigned phase;
        out_ch.ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_result({out_ch.reg_out, out_ch.status, out_ch.answer,
                                 out_ch.stack_count, out_ch.temps_used,
                                 out_ch.highest_temp, out_ch.error_flag});
            phase++;
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (!stall_enable)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ((phase % 11) < 7) && ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (items_sent > 600);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    task automatic send_item(alloc_op_t op, logic [7:0] r, logic prot);
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.reg_in  <= r;
        in_ch.protect <= prot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_item(op, r, prot);
        items_sent++;
    endtask

    task automatic idle_gap(int unsigned n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        int unsigned guard;
        idle_gap(0);
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_locals(logic [8:0] n);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.locals = 32'(n);
    endtask

    function automatic alloc_op_t pick_op();
        int unsigned w;
        w = $urandom_range(0, 99);
        if (w < 22) return OP_ALLOC;
        if (w < 30) return OP_ALLOC_KEPT;
        if (w < 36) return OP_PUSH_REG;
        if (w < 56) return OP_POP;
        if (w < 61) return OP_PUSH_CTX;
        if (w < 65) return OP_POP_CTX;
        if (w < 69) return OP_PROTECT_OUT;
        if (w < 73) return OP_PROTECT_IN;
        if (w < 77) return OP_CLEAR;
        if (w < 80) return OP_SET;
        if (w < 83) return OP_KEEP;
        if (w < 86) return OP_UNKEEP;
        if (w < 89) return OP_CLEAR_TEMPS;
        if (w < 94) return OP_FIRST_FREE;
        if (w < 99) return OP_PEEK;
        return OP_INIT;
    endfunction

    task automatic random_phase(int unsigned count);
        int unsigned burst;
        int unsigned done;
        logic [7:0]  r;
        done = 0;
        while (done < count)
        begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && done < count; i++)
            begin
                r = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 40));
                send_item(pick_op(), r, 1'($urandom_range(0, 1)));
                done++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        logic [8:0] locals_list [6];
        sb = new();
        items_sent = 0;
        stall_enable = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_INIT;
        in_ch.reg_in = '0;
        in_ch.protect = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stack, no context, every opcode
        send_item(OP_POP, 8'd0, 1'b0);
        send_item(OP_PEEK, 8'd0, 1'b0);
        send_item(OP_POP_CTX, 8'd0, 1'b0);
        send_item(OP_PROTECT_IN, 8'd5, 1'b0);
        send_item(OP_PROTECT_OUT, 8'd0, 1'b0);
        send_item(OP_ALLOC, 8'd0, 1'b0);
        send_item(OP_ALLOC_KEPT, 8'd0, 1'b0);
        send_item(OP_POP, 8'd0, 1'b1);
        send_item(OP_PUSH_REG, 8'd255, 1'b0);
        send_item(OP_PEEK, 8'd0, 1'b0);
        send_item(OP_PUSH_CTX, 8'd0, 1'b0);
        send_item(OP_POP, 8'd0, 1'b1);
        send_item(OP_PROTECT_OUT, 8'd255, 1'b0);
        send_item(OP_PROTECT_OUT, 8'd200, 1'b0);
        send_item(OP_SET, 8'd0, 1'b0);
        send_item(OP_CLEAR, 8'd0, 1'b0);
        send_item(OP_KEEP, 8'd2, 1'b0);
        send_item(OP_UNKEEP, 8'd255, 1'b0);
        send_item(OP_CLEAR_TEMPS, 8'd0, 1'b0);
        send_item(OP_POP_CTX, 8'd0, 1'b0);
        send_item(OP_FIRST_FREE, 8'd0, 1'b0);
        for (int i = 0; i < 17; i++)
            send_item(OP_PUSH_CTX, 8'd0, 1'b0);
        send_item(OP_INIT, 8'd0, 1'b0);
        drain();

        // exhaust the bitmap, then overflow the stack
        for (int i = 0; i < 257; i++)
            send_item(OP_ALLOC, 8'd0, 1'b0);
        send_item(OP_FIRST_FREE, 8'd0, 1'b0);
        send_item(OP_PUSH_REG, 8'd7, 1'b0);
        send_item(OP_PUSH_REG, 8'd8, 1'b0);
        send_item(OP_ALLOC, 8'd0, 1'b0);
        send_item(OP_CLEAR_TEMPS, 8'd0, 1'b0);
        send_item(OP_INIT, 8'd0, 1'b0);
        drain();

        // temp counter saturation: fill the stack, then pop and push again
        for (int i = 0; i < 256; i++)
            send_item(OP_PUSH_REG, 8'(i), 1'b0);
        for (int i = 0; i < 256; i++)
        begin
            send_item(OP_POP, 8'd0, 1'b0);
            send_item(OP_PUSH_REG, 8'(i), 1'b0);
        end
        drain();

        stall_enable = 1'b1;
        locals_list = '{9'd256, 9'd0, 9'd17, 9'd255, 9'd1, 9'd100};
        foreach (locals_list[k])
        begin
            write_locals(locals_list[k]);
            send_item(OP_INIT, 8'd0, 1'b0);
            random_phase(90);
            drain();
        end
        write_locals(9'd3);
        random_phase(90);
        drain();

        $display("run covered %0d items, %0d results, seven num_locals settings",
                 items_sent, sb.results_seen);
        $display("including bitmap exhaustion, stack overflow, temp count saturation"
                 , " and context limits");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** register_bitmap_allocator_stack_core: PASSED **");
        else
            $display("** register_bitmap_allocator_stack_core: FAILED **");
        $finish;
    end

endmodule
